[rtl/rsi_pkg.sv]
// rsi_pkg: shared widths, fixed-point constants and payload types for the
// ray against wall segment intersection block
// no dependencies
package rsi_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int ANGLE_WIDTH = 16;
  localparam int DIST_WIDTH  = 23;
  localparam int QUEUE_DEPTH = 4;

  // ray offset along one axis, signed, magnitude below 2^DIST_WIDTH
  localparam int OFS_WIDTH   = DIST_WIDTH + 1;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int END_WIDTH   = ((COORD_WIDTH > OFS_WIDTH) ? COORD_WIDTH : OFS_WIDTH) + 1;
  localparam int EDIFF_WIDTH = END_WIDTH + 1;
  localparam int C12_WIDTH   = OFS_WIDTH + DIFF_WIDTH + 1;
  localparam int C3_FULL     = 2 * DIFF_WIDTH + 1;
  localparam int C3_WIDTH    = (C3_FULL > 64) ? 64 : C3_FULL;
  localparam int C4_FULL     = DIFF_WIDTH + EDIFF_WIDTH + 1;
  localparam int C4_WIDTH    = (C4_FULL > 64) ? 64 : C4_FULL;
  localparam int DEN_WIDTH   = OFS_WIDTH + DIFF_WIDTH + 1;
  localparam int MAG_WIDTH   = (C3_WIDTH > DEN_WIDTH) ? C3_WIDTH : DEN_WIDTH;
  localparam int FRAC_WIDTH  = 32;
  localparam int SUMSQ_WIDTH = 2 * OFS_WIDTH - 1;
  localparam int ROOT_WIDTH  = (SUMSQ_WIDTH + 1) / 2;

  // sine polynomial, Q16
  localparam int ARG_WIDTH = 17;
  localparam logic [ARG_WIDTH-1:0] SIN_A   = 17'd102944;
  localparam logic [ARG_WIDTH-1:0] SIN_B   = 17'd42047;
  localparam logic [ARG_WIDTH-1:0] SIN_C   = 17'd4640;
  localparam logic [ARG_WIDTH-1:0] Q16_ONE = 17'd65536;
  localparam logic [ANGLE_WIDTH-1:0] ANGLE_QUARTER = {2'b01, {(ANGLE_WIDTH-2){1'b0}}};

  localparam logic [DIST_WIDTH-1:0] MAX_DIST_RESET = 23'd256000;

  typedef enum logic [1:0] {
    FRAC_ZERO,
    FRAC_FULL,
    FRAC_DIVIDE
  } frac_mode_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic        [ANGLE_WIDTH-1:0] ray_angle;
    logic signed [COORD_WIDTH-1:0] wall_start_x;
    logic signed [COORD_WIDTH-1:0] wall_start_y;
    logic signed [COORD_WIDTH-1:0] wall_end_x;
    logic signed [COORD_WIDTH-1:0] wall_end_y;
  } ray_req_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] hit_x;
    logic signed [COORD_WIDTH-1:0] hit_y;
    logic        [DIST_WIDTH-1:0]  distance;
  } ray_res_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                          hit;
    frac_mode_t                    mode;
    logic        [MAG_WIDTH-1:0]   num_mag;
    logic        [MAG_WIDTH-1:0]   den_mag;
    logic signed [OFS_WIDTH-1:0]   dx;
    logic signed [OFS_WIDTH-1:0]   dy;
    logic signed [COORD_WIDTH-1:0] x1;
    logic signed [COORD_WIDTH-1:0] y1;
  } rsi_job_t;

endpackage

[rtl/ray_segment_intersect.sv]
// ray_segment_intersect: tests one ray against one wall segment per request
// throughput: one request per cycle while the receiver takes results, set by
// the fully pipelined divider (32 steps) and square root (24 steps); the front
// stalls only when its queue is full
// reset: synchronous active-high rst empties both pipelines and the queue and
// loads max_distance with 256000
module ray_segment_intersect import rsi_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [DIST_WIDTH-1:0] cfg_wr_data,
  input  logic                  ray_valid,
  output logic                  ray_ready,
  input  ray_req_t              ray,
  output logic                  result_valid,
  input  logic                  result_ready,
  output ray_res_t              result
);

  // ray length and miss distance, only rewritten while the block is idle (a user duty, unchecked)
  logic [DIST_WIDTH-1:0] max_distance;

  // front to queue
  logic     push;
  logic     q_full;
  rsi_job_t push_job;

  // queue to back
  logic     q_nonempty;
  logic     pop;
  rsi_job_t head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= MAX_DIST_RESET;
    end else if (cfg_wr_en) begin
      max_distance <= cfg_wr_data;
    end
  end

  // front: sine lanes, ray end point, cross products and classification
  rsi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .max_distance (max_distance),
    .ray_valid    (ray_valid),
    .ray_ready    (ray_ready),
    .ray          (ray),
    .push         (push),
    .job          (push_job),
    .full         (q_full)
  );

  // short queue so a stalled consumer does not freeze the front at once
  rsi_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (pop),
    .head      (head_job),
    .nonempty  (q_nonempty)
  );

  // back: fraction, intersection point and rounded distance
  rsi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .max_distance (max_distance),
    .job_valid    (q_nonempty),
    .pop          (pop),
    .job          (head_job),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[rtl/rsi_front.sv]
// rsi_front: accepts requests, builds the ray end point from a polynomial
// sine and classifies the crossing with five cross products
// depends on rsi_pkg
module rsi_front import rsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DIST_WIDTH-1:0] max_distance,
  input  logic                  ray_valid,
  output logic                  ray_ready,
  input  ray_req_t              ray,
  output logic                  push,
  output rsi_job_t              job,
  input  logic                  full
);

  localparam int NSTAGE = 10;

  logic [NSTAGE-1:0] vld;
  logic              en;

  ray_req_t s1_req, s2_req, s3_req, s4_req, s5_req, s6_req;

  logic [ARG_WIDTH-1:0] s2_arg [2];
  logic [ARG_WIDTH-1:0] s2_sq  [2];
  logic                 s2_neg [2];
  logic [ARG_WIDTH-1:0] s3_arg [2];
  logic [ARG_WIDTH-1:0] s3_sq  [2];
  logic [ARG_WIDTH-1:0] s3_t1  [2];
  logic                 s3_neg [2];
  logic [ARG_WIDTH-1:0] s4_arg [2];
  logic [ARG_WIDTH-1:0] s4_t2  [2];
  logic                 s4_neg [2];
  logic [ARG_WIDTH-1:0] s5_s   [2];
  logic                 s5_neg [2];
  logic signed [OFS_WIDTH-1:0] s6_off [2];

  logic [ARG_WIDTH-1:0] f2_arg [2];
  logic [ARG_WIDTH-1:0] f2_sq  [2];
  logic                 f2_neg [2];
  logic [ARG_WIDTH-1:0] f3_t1  [2];
  logic [ARG_WIDTH-1:0] f4_t2  [2];
  logic [ARG_WIDTH-1:0] f5_s   [2];
  logic signed [OFS_WIDTH-1:0] f6_off [2];

  logic signed [OFS_WIDTH-1:0]   s7_dx, s7_dy;
  logic signed [DIFF_WIDTH-1:0]  s7_ex, s7_ey, s7_d31x, s7_d31y, s7_d41x, s7_d41y;
  logic signed [EDIFF_WIDTH-1:0] s7_d23x, s7_d23y;
  logic signed [COORD_WIDTH-1:0] s7_x1, s7_y1;
  logic signed [END_WIDTH-1:0]   f7_x2, f7_y2;

  logic signed [OFS_WIDTH+DIFF_WIDTH-1:0]    s8_p1a, s8_p1b, s8_p2a, s8_p2b;
  logic signed [2*DIFF_WIDTH-1:0]            s8_p3a, s8_p3b;
  logic signed [DIFF_WIDTH+EDIFF_WIDTH-1:0]  s8_p4a, s8_p4b;
  logic signed [OFS_WIDTH+DIFF_WIDTH-1:0]    s8_pda, s8_pdb;
  logic signed [OFS_WIDTH-1:0]               s8_dx, s8_dy;
  logic signed [COORD_WIDTH-1:0]             s8_x1, s8_y1;

  logic signed [C12_WIDTH-1:0]   s9_c1, s9_c2;
  logic        [C3_WIDTH-1:0]    s9_c3;
  logic        [C4_WIDTH-1:0]    s9_c4;
  logic        [DEN_WIDTH-1:0]   s9_den;
  logic signed [OFS_WIDTH-1:0]   s9_dx, s9_dy;
  logic signed [COORD_WIDTH-1:0] s9_x1, s9_y1;
  logic signed [C3_FULL-1:0]     f9_c3;
  logic signed [C4_FULL-1:0]     f9_c4;

  rsi_job_t s10_job, f10_job;

  assign en        = !vld[NSTAGE-1] || !full;
  assign ray_ready = en;
  assign push      = vld[NSTAGE-1] && !full;
  assign job       = s10_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], ray_valid};
    end
  end

  // lane 0 gives the x offset (sine), lane 1 the y offset (cosine)
  always_comb begin
    logic [ANGLE_WIDTH-1:0]    ang;
    logic [ANGLE_WIDTH+13:0]   xw;
    logic [ARG_WIDTH-1:0]      x;
    logic [2*ARG_WIDTH-1:0]    p2, p3, p4, p5;
    logic [ARG_WIDTH:0]        sh;
    logic [DIST_WIDTH+ARG_WIDTH:0] p6;
    logic [DIST_WIDTH-1:0]     m;
    for (int l = 0; l < 2; l++) begin
      ang = (l == 0) ? s1_req.ray_angle : s1_req.ray_angle + ANGLE_QUARTER;
      xw  = {ang[ANGLE_WIDTH-3:0], 16'b0} >> (ANGLE_WIDTH - 2);
      x   = xw[ARG_WIDTH-1:0];
      f2_arg[l] = ang[ANGLE_WIDTH-2] ? Q16_ONE - x : x;
      f2_neg[l] = ang[ANGLE_WIDTH-1];
      p2 = (2*ARG_WIDTH)'(f2_arg[l]) * (2*ARG_WIDTH)'(f2_arg[l]);
      f2_sq[l] = p2[ARG_WIDTH+15:16];

      p3 = (2*ARG_WIDTH)'(SIN_C) * (2*ARG_WIDTH)'(s2_sq[l]);
      f3_t1[l] = SIN_B - p3[ARG_WIDTH+15:16];

      p4 = (2*ARG_WIDTH)'(s3_t1[l]) * (2*ARG_WIDTH)'(s3_sq[l]);
      f4_t2[l] = SIN_A - p4[ARG_WIDTH+15:16];

      p5 = (2*ARG_WIDTH)'(s4_arg[l]) * (2*ARG_WIDTH)'(s4_t2[l]);
      sh = p5[ARG_WIDTH+16:16];
      f5_s[l] = (sh > (ARG_WIDTH+1)'(Q16_ONE)) ? Q16_ONE : sh[ARG_WIDTH-1:0];

      p6 = (DIST_WIDTH+ARG_WIDTH+1)'(max_distance) * (DIST_WIDTH+ARG_WIDTH+1)'(s5_s[l])
         + (DIST_WIDTH+ARG_WIDTH+1)'(32768);
      m  = p6[DIST_WIDTH+15:16];
      f6_off[l] = (s5_neg[l] && s5_s[l] != '0) ? OFS_WIDTH'(0) - OFS_WIDTH'(m)
                                               : OFS_WIDTH'(m);
    end
  end

  assign f7_x2 = END_WIDTH'(s6_req.origin_x) + END_WIDTH'(s6_off[0]);
  assign f7_y2 = END_WIDTH'(s6_req.origin_y) + END_WIDTH'(s6_off[1]);

  assign f9_c3 = C3_FULL'(s8_p3a) - C3_FULL'(s8_p3b);
  assign f9_c4 = C4_FULL'(s8_p4a) - C4_FULL'(s8_p4b);

  always_comb begin
    logic              opp12, opp34;
    logic [C3_WIDTH-1:0]  c3neg;
    logic [DEN_WIDTH-1:0] dneg;
    opp12 = s9_c1 != '0 && s9_c2 != '0 && s9_c1[C12_WIDTH-1] != s9_c2[C12_WIDTH-1];
    opp34 = s9_c3 != '0 && s9_c4 != '0 && s9_c3[C3_WIDTH-1] != s9_c4[C4_WIDTH-1];
    c3neg = C3_WIDTH'(0) - s9_c3;
    dneg  = DEN_WIDTH'(0) - s9_den;
    f10_job.hit     = opp12 && opp34 && s9_den != '0;
    f10_job.num_mag = s9_c3[C3_WIDTH-1] ? MAG_WIDTH'(c3neg) : MAG_WIDTH'(s9_c3);
    f10_job.den_mag = s9_den[DEN_WIDTH-1] ? MAG_WIDTH'(dneg) : MAG_WIDTH'(s9_den);
    if (s9_c3 != '0 && s9_c3[C3_WIDTH-1] != s9_den[DEN_WIDTH-1]) begin
      f10_job.mode = FRAC_ZERO;
    end else if (f10_job.num_mag >= f10_job.den_mag) begin
      f10_job.mode = FRAC_FULL;
    end else begin
      f10_job.mode = FRAC_DIVIDE;
    end
    f10_job.dx = s9_dx;
    f10_job.dy = s9_dy;
    f10_job.x1 = s9_x1;
    f10_job.y1 = s9_y1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_req <= ray;
      s2_req <= s1_req;
      s3_req <= s2_req;
      s4_req <= s3_req;
      s5_req <= s4_req;
      s6_req <= s5_req;
      for (int l = 0; l < 2; l++) begin
        s2_arg[l] <= f2_arg[l];
        s2_sq[l]  <= f2_sq[l];
        s2_neg[l] <= f2_neg[l];
        s3_arg[l] <= s2_arg[l];
        s3_sq[l]  <= s2_sq[l];
        s3_t1[l]  <= f3_t1[l];
        s3_neg[l] <= s2_neg[l];
        s4_arg[l] <= s3_arg[l];
        s4_t2[l]  <= f4_t2[l];
        s4_neg[l] <= s3_neg[l];
        s5_s[l]   <= f5_s[l];
        s5_neg[l] <= s4_neg[l];
        s6_off[l] <= f6_off[l];
      end

      s7_dx   <= s6_off[0];
      s7_dy   <= s6_off[1];
      s7_ex   <= DIFF_WIDTH'(s6_req.wall_end_x) - DIFF_WIDTH'(s6_req.wall_start_x);
      s7_ey   <= DIFF_WIDTH'(s6_req.wall_end_y) - DIFF_WIDTH'(s6_req.wall_start_y);
      s7_d31x <= DIFF_WIDTH'(s6_req.wall_start_x) - DIFF_WIDTH'(s6_req.origin_x);
      s7_d31y <= DIFF_WIDTH'(s6_req.wall_start_y) - DIFF_WIDTH'(s6_req.origin_y);
      s7_d41x <= DIFF_WIDTH'(s6_req.wall_end_x) - DIFF_WIDTH'(s6_req.origin_x);
      s7_d41y <= DIFF_WIDTH'(s6_req.wall_end_y) - DIFF_WIDTH'(s6_req.origin_y);
      s7_d23x <= EDIFF_WIDTH'(f7_x2) - EDIFF_WIDTH'(s6_req.wall_start_x);
      s7_d23y <= EDIFF_WIDTH'(f7_y2) - EDIFF_WIDTH'(s6_req.wall_start_y);
      s7_x1   <= s6_req.origin_x;
      s7_y1   <= s6_req.origin_y;

      s8_p1a <= s7_dx * s7_d31y;
      s8_p1b <= s7_dy * s7_d31x;
      s8_p2a <= s7_dx * s7_d41y;
      s8_p2b <= s7_dy * s7_d41x;
      s8_p3a <= s7_ey * s7_d31x;
      s8_p3b <= s7_ex * s7_d31y;
      s8_p4a <= s7_ex * s7_d23y;
      s8_p4b <= s7_ey * s7_d23x;
      s8_pda <= s7_dx * s7_ey;
      s8_pdb <= s7_dy * s7_ex;
      s8_dx  <= s7_dx;
      s8_dy  <= s7_dy;
      s8_x1  <= s7_x1;
      s8_y1  <= s7_y1;

      // cross products keep their full width; c3 and c4 stay below the 64-bit cap
      s9_c1  <= C12_WIDTH'(s8_p1a) - C12_WIDTH'(s8_p1b);
      s9_c2  <= C12_WIDTH'(s8_p2a) - C12_WIDTH'(s8_p2b);
      s9_c3  <= f9_c3[C3_WIDTH-1:0];
      s9_c4  <= f9_c4[C4_WIDTH-1:0];
      s9_den <= DEN_WIDTH'(s8_pda) - DEN_WIDTH'(s8_pdb);
      s9_dx  <= s8_dx;
      s9_dy  <= s8_dy;
      s9_x1  <= s8_x1;
      s9_y1  <= s8_y1;

      s10_job <= f10_job;
    end
  end

endmodule

[rtl/rsi_queue.sv]
// rsi_queue: small request queue between the classifying front and the
// arithmetic back
// depends on rsi_pkg
module rsi_queue import rsi_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rsi_job_t push_data,
  output logic     full,
  input  logic     pop,
  output rsi_job_t head,
  output logic     nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rsi_job_t             slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [CNT_W-1:0]     count;

  assign full     = count == CNT_W'(DEPTH);
  assign nonempty = count != '0;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/rsi_back.sv]
// rsi_back: pipelined fraction divider, point scaling and rounded square
// root, one step per stage, ending in the result register
// depends on rsi_pkg
module rsi_back import rsi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DIST_WIDTH-1:0] max_distance,
  input  logic                  job_valid,
  output logic                  pop,
  input  rsi_job_t              job,
  output logic                  result_valid,
  input  logic                  result_ready,
  output ray_res_t              result
);

  localparam int SC     = FRAC_WIDTH + 1;
  localparam int SQ     = SC + 1;
  localparam int OUTS   = SQ + ROOT_WIDTH + 1;
  localparam int NV     = OUTS + 1;
  localparam int RW     = 2 * ROOT_WIDTH + 1;
  localparam int PW     = FRAC_WIDTH + OFS_WIDTH;
  localparam int MW     = OFS_WIDTH - 1;
  localparam int RND_W  = ROOT_WIDTH + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_WIDTH - 1);

  typedef struct packed {
    logic                          hit;
    frac_mode_t                    mode;
    logic signed [OFS_WIDTH-1:0]   dx;
    logic signed [OFS_WIDTH-1:0]   dy;
    logic signed [COORD_WIDTH-1:0] x1;
    logic signed [COORD_WIDTH-1:0] y1;
  } carry_t;

  logic [NV-1:0] vld;
  logic          en;

  logic [MAG_WIDTH-1:0]  div_rem [FRAC_WIDTH+1];
  logic [MAG_WIDTH-1:0]  div_den [FRAC_WIDTH+1];
  logic [FRAC_WIDTH-1:0] div_q   [FRAC_WIDTH+1];
  carry_t                div_c   [FRAC_WIDTH+1];

  logic [MW-1:0]                 sc_mx, sc_my;
  logic                          sc_nx, sc_ny, sc_hit;
  logic signed [COORD_WIDTH-1:0] sc_x1, sc_y1;

  logic [RW-1:0]                 rt_rem  [ROOT_WIDTH+1];
  logic [ROOT_WIDTH-1:0]         rt_root [ROOT_WIDTH+1];
  logic signed [COORD_WIDTH-1:0] rt_hx   [ROOT_WIDTH+1];
  logic signed [COORD_WIDTH-1:0] rt_hy   [ROOT_WIDTH+1];
  logic                          rt_hit  [ROOT_WIDTH+1];

  logic [FRAC_WIDTH-1:0] tq;
  logic [OFS_WIDTH-1:0]  ax, ay, dxu, dyu;
  logic [PW-1:0]         px, py;
  logic signed [OFS_WIDTH-1:0] ox, oy;
  logic signed [END_WIDTH-1:0] sx, sy;
  logic [RND_W-1:0]      rounded;

  assign en           = !vld[NV-1] || result_ready;
  assign pop          = en && job_valid;
  assign result_valid = vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], job_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_rem[0]     <= job.num_mag;
      div_den[0]     <= job.den_mag;
      div_q[0]       <= '0;
      div_c[0].hit   <= job.hit;
      div_c[0].mode  <= job.mode;
      div_c[0].dx    <= job.dx;
      div_c[0].dy    <= job.dy;
      div_c[0].x1    <= job.x1;
      div_c[0].y1    <= job.y1;
    end
  end

  // one quotient bit per stage, remainder kept below the divisor in divide mode
  for (genvar k = 1; k <= FRAC_WIDTH; k++) begin : g_div
    logic [MAG_WIDTH:0] twice, diff;
    assign twice = {div_rem[k-1], 1'b0};
    assign diff  = twice - {1'b0, div_den[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (twice >= {1'b0, div_den[k-1]}) begin
          div_rem[k] <= diff[MAG_WIDTH-1:0];
          div_q[k]   <= {div_q[k-1][FRAC_WIDTH-2:0], 1'b1};
        end else begin
          div_rem[k] <= twice[MAG_WIDTH-1:0];
          div_q[k]   <= {div_q[k-1][FRAC_WIDTH-2:0], 1'b0};
        end
        div_den[k] <= div_den[k-1];
        div_c[k]   <= div_c[k-1];
      end
    end
  end

  always_comb begin
    case (div_c[FRAC_WIDTH].mode)
      FRAC_ZERO:   tq = '0;
      FRAC_FULL:   tq = '1;
      default:     tq = div_q[FRAC_WIDTH];
    endcase
  end

  assign dxu = div_c[FRAC_WIDTH].dx;
  assign dyu = div_c[FRAC_WIDTH].dy;
  assign ax  = dxu[OFS_WIDTH-1] ? OFS_WIDTH'(0) - dxu : dxu;
  assign ay  = dyu[OFS_WIDTH-1] ? OFS_WIDTH'(0) - dyu : dyu;
  assign px  = PW'(tq) * PW'(ax) + HALF;
  assign py  = PW'(tq) * PW'(ay) + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      sc_mx  <= px[FRAC_WIDTH+MW-1:FRAC_WIDTH];
      sc_my  <= py[FRAC_WIDTH+MW-1:FRAC_WIDTH];
      sc_nx  <= dxu[OFS_WIDTH-1];
      sc_ny  <= dyu[OFS_WIDTH-1];
      sc_hit <= div_c[FRAC_WIDTH].hit;
      sc_x1  <= div_c[FRAC_WIDTH].x1;
      sc_y1  <= div_c[FRAC_WIDTH].y1;
    end
  end

  assign ox = sc_nx ? OFS_WIDTH'(0) - OFS_WIDTH'(sc_mx) : OFS_WIDTH'(sc_mx);
  assign oy = sc_ny ? OFS_WIDTH'(0) - OFS_WIDTH'(sc_my) : OFS_WIDTH'(sc_my);
  assign sx = END_WIDTH'(sc_x1) + END_WIDTH'(ox);
  assign sy = END_WIDTH'(sc_y1) + END_WIDTH'(oy);

  always_ff @(posedge clk) begin
    if (en) begin
      rt_rem[0]  <= RW'(SUMSQ_WIDTH'(sc_mx) * SUMSQ_WIDTH'(sc_mx)
                      + SUMSQ_WIDTH'(sc_my) * SUMSQ_WIDTH'(sc_my));
      rt_root[0] <= '0;
      rt_hx[0]   <= sx[COORD_WIDTH-1:0];
      rt_hy[0]   <= sy[COORD_WIDTH-1:0];
      rt_hit[0]  <= sc_hit;
    end
  end

  // one root bit per stage, remainder holds value minus root squared
  for (genvar k = 1; k <= ROOT_WIDTH; k++) begin : g_root
    localparam int B = ROOT_WIDTH - k;
    logic [RW-1:0] trial;
    assign trial = (RW'(rt_root[k-1]) << (B + 1)) + (RW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rt_rem[k-1] >= trial) begin
          rt_rem[k]  <= rt_rem[k-1] - trial;
          rt_root[k] <= rt_root[k-1] | (ROOT_WIDTH'(1) << B);
        end else begin
          rt_rem[k]  <= rt_rem[k-1];
          rt_root[k] <= rt_root[k-1];
        end
        rt_hx[k]  <= rt_hx[k-1];
        rt_hy[k]  <= rt_hy[k-1];
        rt_hit[k] <= rt_hit[k-1];
      end
    end
  end

  assign rounded = RND_W'(rt_root[ROOT_WIDTH])
                 + RND_W'(rt_rem[ROOT_WIDTH] > RW'(rt_root[ROOT_WIDTH]));

  always_ff @(posedge clk) begin
    if (en) begin
      if (rt_hit[ROOT_WIDTH]) begin
        result.hit   <= 1'b1;
        result.hit_x <= rt_hx[ROOT_WIDTH];
        result.hit_y <= rt_hy[ROOT_WIDTH];
        result.distance <= (rounded > RND_W'(max_distance)) ? max_distance
                                                            : rounded[DIST_WIDTH-1:0];
      end else begin
        result.hit      <= 1'b0;
        result.hit_x    <= '0;
        result.hit_y    <= '0;
        result.distance <= max_distance;
      end
    end
  end

endmodule

[test/tb_ray_segment_intersect.sv]
// tb_ray_segment_intersect: self-checking bench for the ray against wall
// segment intersection block, with its own fixed-point predictor
// depends on rsi_pkg and ray_segment_intersect
`timescale 1ns / 1ps

module tb_ray_segment_intersect;
  import rsi_pkg::*;

  localparam int PIPE_LAT = 90;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [DIST_WIDTH-1:0] cfg_wr_data = '0;
  logic ray_valid = 1'b0;
  logic ray_ready;
  ray_req_t ray = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  ray_res_t result;

  ray_segment_intersect dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .ray_valid(ray_valid), .ray_ready(ray_ready), .ray(ray),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [DIST_WIDTH-1:0] ray_len;
  ray_res_t expected_hits[$];
  int n_bad = 0;
  bit stall_on = 1'b0;

  // quarter-wave sine polynomial, Q16, same constants as the hardware, 64-bit arithmetic
  function automatic logic [63:0] quarter_sin(input logic [63:0] x);
    logic [63:0] x2, t;
    x2 = (x * x) >> 16;
    t = 64'd42047 - ((64'd4640 * x2) >> 16);
    t = 64'd102944 - ((t * x2) >> 16);
    t = (x * t) >> 16;
    return (t > 64'd65536) ? 64'd65536 : t;
  endfunction

  // signed ray offset along one axis for the given angle
  function automatic logic [63:0] axis_offset(input logic [ANGLE_WIDTH-1:0] a);
    logic [1:0] quad;
    logic [63:0] frac, s, m;
    quad = a[ANGLE_WIDTH-1 -: 2];
    frac = ({50'd0, a[ANGLE_WIDTH-3:0]} << 16) >> (ANGLE_WIDTH - 2);
    s = quad[0] ? quarter_sin(64'd65536 - frac) : quarter_sin(frac);
    m = ({41'd0, ray_len} * s + 64'd32768) >> 16;
    return (quad[1] && s != 0) ? -m : m;
  endfunction

  function automatic logic [63:0] cross2(input logic [63:0] ax, ay, bx, by, cx, cy);
    return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
  endfunction

  function automatic bit straddles(input logic [63:0] c, d);
    return c != 0 && d != 0 && c[63] != d[63];
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] scale_frac(input logic [63:0] tq, d);
    logic [63:0] m;
    m = (tq * abs64(d) + 64'h8000_0000) >> 32;
    return d[63] ? -m : m;
  endfunction

  function automatic logic [63:0] sqrt_round(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return (v > r) ? r + 1 : r;
  endfunction

  function automatic ray_res_t trace_wall(input ray_req_t q);
    logic [63:0] x1, y1, x2, y2, x3, y3, x4, y4, c1, c2, c3, c4;
    logic [63:0] dx, dy, ex, ey, den, num, n, d, tq, ox, oy, reach;
    ray_res_t r;
    x1 = 64'(q.origin_x);     y1 = 64'(q.origin_y);
    x3 = 64'(q.wall_start_x); y3 = 64'(q.wall_start_y);
    x4 = 64'(q.wall_end_x);   y4 = 64'(q.wall_end_y);
    x2 = x1 + axis_offset(q.ray_angle);
    y2 = y1 + axis_offset(q.ray_angle + ANGLE_QUARTER);
    c1 = cross2(x1, y1, x2, y2, x3, y3);
    c2 = cross2(x1, y1, x2, y2, x4, y4);
    c3 = cross2(x3, y3, x4, y4, x1, y1);
    c4 = cross2(x3, y3, x4, y4, x2, y2);
    r = '0;
    r.distance = ray_len;
    if (straddles(c1, c2) && straddles(c3, c4)) begin
      dx = x2 - x1; dy = y2 - y1; ex = x4 - x3; ey = y4 - y3;
      den = dx * ey - dy * ex;
      num = (x3 - x1) * ey - (y3 - y1) * ex;
      // zero determinant counts as a miss
      if (den == 0) return r;
      n = abs64(num);
      d = abs64(den);
      if (num != 0 && num[63] != den[63]) begin
        tq = 0;
      end else if (n >= d) begin
        tq = 64'hFFFF_FFFF;
      end else begin
        tq = 0;
        for (int i = 0; i < 32; i++) begin
          tq = tq << 1;
          if (n >= d - n) begin
            n = n - (d - n);
            tq[0] = 1'b1;
          end else begin
            n = n << 1;
          end
        end
      end
      ox = scale_frac(tq, dx);
      oy = scale_frac(tq, dy);
      reach = sqrt_round(ox * ox + oy * oy);
      if (reach > {41'd0, ray_len}) reach = {41'd0, ray_len};
      r.hit = 1'b1;
      r.hit_x = COORD_WIDTH'(x1 + ox);
      r.hit_y = COORD_WIDTH'(y1 + oy);
      r.distance = DIST_WIDTH'(reach);
    end
    return r;
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_hits.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %p", result);
      end else begin
        if (result.hit !== expected_hits[0].hit || result.hit_x !== expected_hits[0].hit_x ||
            result.hit_y !== expected_hits[0].hit_y ||
            result.distance !== expected_hits[0].distance) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: expected %p actual %p", expected_hits[0], result);
        end
        void'(expected_hits.pop_front());
      end
    end
  end

  // receiver stall pattern, changed at the falling edge
  always @(negedge clk) begin
    if (!stall_on) result_ready <= 1'b1;
    else result_ready <= ($urandom_range(0, 3) != 0);
  end

  // sender: hold the request until accepted; rows may carry a typed answer
  // valid stays high afterwards so the next request can follow at once
  task automatic push_request(input ray_req_t q, input bit known, input ray_res_t ans);
    ray_res_t e;
    e = known ? ans : trace_wall(q);
    ray <= q;
    ray_valid <= 1'b1;
    @(posedge clk);
    while (!ray_ready) @(posedge clk);
    expected_hits.push_back(e);
    @(negedge clk);
  endtask

  // sender goes idle for the given number of cycles
  task automatic sender_pause(input int cycles);
    if (cycles > 0) begin
      ray_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic drain_pipe;
    ray_valid <= 1'b0;
    @(negedge clk);
    while (expected_hits.size() != 0) @(negedge clk);
    repeat (PIPE_LAT) @(negedge clk);
  endtask

  task automatic write_len(input logic [DIST_WIDTH-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ray_len = v;
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord(input int span);
    if (span == 0) return COORD_WIDTH'($urandom);
    return COORD_WIDTH'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // random walls mostly centred near the ray origin so that hits are common
  function automatic ray_req_t rand_request(input int span);
    ray_req_t q;
    logic signed [31:0] cx, cy;
    q.origin_x = rand_coord(span);
    q.origin_y = rand_coord(span);
    q.ray_angle = ANGLE_WIDTH'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      cx = q.origin_x + $signed($urandom_range(0, 2 * span)) - span;
      cy = q.origin_y + $signed($urandom_range(0, 2 * span)) - span;
      q.wall_start_x = COORD_WIDTH'(cx + $signed($urandom_range(0, 2 * span)) - span);
      q.wall_start_y = COORD_WIDTH'(cy + $signed($urandom_range(0, 2 * span)) - span);
      q.wall_end_x = COORD_WIDTH'(2 * cx - q.wall_start_x);
      q.wall_end_y = COORD_WIDTH'(2 * cy - q.wall_start_y);
    end else begin
      q.wall_start_x = rand_coord(span);
      q.wall_start_y = rand_coord(span);
      q.wall_end_x = rand_coord(span);
      q.wall_end_y = rand_coord(span);
    end
    return q;
  endfunction

  typedef struct {
    ray_req_t req;
    bit known;
    ray_res_t ans;
  } stim_row_t;

  localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] U100 = 24'sd25600;

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    ray_res_t miss;
    int burst;
    int span;
    logic [DIST_WIDTH-1:0] lens[5];

    ray_len = MAX_DIST_RESET;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    miss = '0;
    miss.distance = MAX_DIST_RESET;
    // degenerate wall: a point, no crossing possible
    row.req = '{0, 0, 0, U100, U100, U100, U100}; row.known = 1; row.ans = miss;
    rows.push_back(row);
    // wall parallel to the ray beside it
    row.req = '{0, 0, 0, U100, 0, U100, U100}; rows.push_back(row);
    // collinear overlap along +y
    row.req = '{0, 0, 0, 0, U100, 0, 2 * U100}; rows.push_back(row);
    // ray end just touching the wall at its midpoint
    row.req = '{0, 0, 16'h4000, 24'sd256000, -U100, 24'sd256000, U100}; rows.push_back(row);
    // wall endpoint on the ray line
    row.req = '{0, 0, 0, 0, U100, U100, U100}; rows.push_back(row);
    // wall behind the origin
    row.req = '{0, 0, 0, -U100, -U100, U100, -U100}; rows.push_back(row);
    row.known = 0;
    // straight crossings in each quadrant direction, plus near-axis and diagonal rays
    row.req = '{0, 0, 0, -U100, U100, U100, U100}; rows.push_back(row);
    row.req = '{0, 0, 16'h4000, U100, -U100, U100, U100}; rows.push_back(row);
    row.req = '{0, 0, 16'h8000, -U100, -U100, U100, -U100}; rows.push_back(row);
    row.req = '{0, 0, 16'hC000, -U100, U100, -U100, -U100}; rows.push_back(row);
    row.req = '{0, 0, 16'hFFFF, -U100, U100, U100, U100}; rows.push_back(row);
    row.req = '{0, 0, 16'h2000, 0, U100, U100, 0}; rows.push_back(row);
    // extremes of the coordinate range
    row.req = '{C_MAX, C_MAX, 16'h8000, C_MIN, C_MAX - U100, C_MAX, C_MAX - U100};
    rows.push_back(row);
    row.req = '{C_MIN, C_MIN, 0, C_MIN - U100, C_MIN + U100, C_MAX, C_MIN + U100};
    rows.push_back(row);
    row.req = '{C_MAX, C_MIN, 16'h7FFF, C_MIN, C_MAX, C_MAX, C_MIN}; rows.push_back(row);
    row.req = '{-1, -1, 16'h5555, C_MIN, C_MIN, C_MAX, C_MAX}; rows.push_back(row);

    foreach (rows[i]) push_request(rows[i].req, rows[i].known, rows[i].ans);
    drain_pipe();

    // zero length ray: every item misses with distance zero
    write_len('0);
    miss.distance = '0;
    push_request('{0, 0, 0, -U100, 0, U100, 0}, 1, miss);
    push_request('{0, 0, 16'h4000, 0, -U100, 0, U100}, 1, miss);
    drain_pipe();

    // random phases across several ray lengths, extremes among them
    lens = '{23'd256000, {DIST_WIDTH{1'b1}}, 23'd1, 23'd5000, 23'(($urandom % 23'h7FFFFF))};
    stall_on = 1'b1;
    foreach (lens[p]) begin
      write_len(lens[p]);
      for (int k = 0; k < 130;) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && k < 130; b++, k++) begin
          case ($urandom_range(0, 9))
            0: span = 0;
            1, 2: span = 8000000;
            default: span = (lens[p] > 1000) ? int'(lens[p]) : 4000;
          endcase
          push_request(rand_request(span), 0, '0);
        end
        if (k == 60) begin
          // hold off until the pipe is empty
          ray_valid <= 1'b0;
          @(negedge clk);
          while (expected_hits.size() != 0) @(negedge clk);
        end else begin
          sender_pause($urandom_range(0, 6));
        end
      end
      drain_pipe();
      stall_on = (p % 2 == 0);
    end

    drain_pipe();
    if (n_bad == 0) $display("tb_ray_segment_intersect: done, clean");
    else $display("tb_ray_segment_intersect: done, errors");
    $finish;
  end

  // overall time limit
  initial begin
    #10ms;
    $display("tb_ray_segment_intersect: done, errors");
    $finish;
  end

endmodule

[sim.f]
rtl/rsi_pkg.sv
rtl/rsi_front.sv
rtl/rsi_queue.sv
rtl/rsi_back.sv
rtl/ray_segment_intersect.sv
test/tb_ray_segment_intersect.sv
